### rtl/mrfr_pkg.sv
`default_nettype none
package mrfr_pkg;

   localparam int PEER_SLOTS_DEF   = 64;
   localparam int PAYLOAD_MAX_DEF  = 64;
   localparam int HEADER_BYTES_DEF = 8;
   localparam int QUEUE_DEPTH      = 2;

   typedef enum logic [1:0] {
      OP_FRAME = 2'd0,
      OP_ARM   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      V_BADLEN   = 4'd0,
      V_NOTADDR  = 4'd1,
      V_NOPEER   = 4'd2,
      V_DUP      = 4'd3,
      V_SINGLE   = 4'd4,
      V_FRAG     = 4'd5,
      V_COMPLETE = 4'd6,
      V_SYNC     = 4'd7,
      V_ERR      = 4'd8,
      V_LOST     = 4'd9,
      V_ACK      = 4'd10,
      V_PENDING  = 4'd11
   } verdict_type;

   typedef enum logic {
      CSR_OWN   = 1'b0,
      CSR_BCAST = 1'b1
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CLAIM,
      ST_READ,
      ST_WAIT,
      ST_EXEC,
      ST_OUT
   } state_type;

   localparam int FLAG_REQ   = 0;
   localparam int FLAG_RESP  = 1;
   localparam int FLAG_RETX  = 2;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  frame_len;
      logic [15:0] src_addr;
      logic [15:0] dest_addr;
      logic [7:0]  seq_num;
      logic [3:0]  seq_msg;
      logic [2:0]  seq_idx;
      logic        seq_end;
      logic [15:0] remaining_size;
      logic [2:0]  ack_flags;
      logic [7:0]  first_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]  verdict;
      logic        send_ack;
      logic [7:0]  ack_seq;
      logic        ack_matched;
      logic        ack_duplicate;
      logic [5:0]  peer_slot;
      logic [15:0] write_offset;
      logic [15:0] message_size;
      logic [15:0] message_dest;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      req_type     req;
      logic [3:0]  early;   // verdict if settled by the front
      logic        settled;
      logic        to_me;
   } cls_type;

endpackage
`default_nettype wire

### rtl/mrfr_if.sv
`default_nettype none
interface mrfr_req_if;
   logic                 valid;
   logic                 ready;
   mrfr_pkg::req_type    data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface mrfr_rsp_if;
   logic                 valid;
   logic                 ready;
   mrfr_pkg::rsp_type    data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface mrfr_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [15:0] wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

### rtl/mrfr_ram.sv
`default_nettype none
module mrfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### rtl/mrfr_front.sv
`default_nettype none
module mrfr_front #(
   parameter int PAYLOAD_MAX  = mrfr_pkg::PAYLOAD_MAX_DEF,
   parameter int HEADER_BYTES = mrfr_pkg::HEADER_BYTES_DEF
) (
   input  wire logic           [15:0] own_address,
   input  wire logic           [15:0] broadcast_address,
   mrfr_req_if.sink            req,
   output      logic           q_push,
   output      mrfr_pkg::cls_type q_data,
   input  wire logic           q_full
);
   logic [15:0] pay;
   logic [15:0] need_len;
   logic        to_me;

   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;

   always_comb begin
      pay      = (req.data.remaining_size < 16'(PAYLOAD_MAX)) ?
                 req.data.remaining_size : 16'(PAYLOAD_MAX);
      need_len = pay + 16'(HEADER_BYTES);
      to_me    = (req.data.dest_addr == own_address);
      q_data.req     = req.data;
      q_data.to_me   = to_me;
      q_data.settled = 1'b1;
      q_data.early   = mrfr_pkg::V_PENDING;
      if (req.data.op == mrfr_pkg::OP_FRAME) begin
         if ({8'd0, req.data.frame_len} != need_len) begin
            q_data.early = mrfr_pkg::V_BADLEN;
         end else if (req.data.dest_addr != broadcast_address && !to_me) begin
            q_data.early = mrfr_pkg::V_NOTADDR;
         end else if (req.data.src_addr == 16'd0) begin
            q_data.early = mrfr_pkg::V_NOPEER;
         end else begin
            // answer used when the peer table has no room
            q_data.early   = mrfr_pkg::V_NOPEER;
            q_data.settled = 1'b0;
         end
      end
   end
endmodule
`default_nettype wire

### rtl/mrfr_queue.sv
`default_nettype none
module mrfr_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire mrfr_pkg::cls_type push_data,
   output      logic              full,
   input  wire logic              pop,
   output      logic              empty,
   output      mrfr_pkg::cls_type pop_data
);
   localparam int AW = $clog2(mrfr_pkg::QUEUE_DEPTH);
   mrfr_pkg::cls_type    buf_ff [mrfr_pkg::QUEUE_DEPTH];
   logic [AW-1:0]        wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]          cnt_ff, cnt_in;

   assign full     = (cnt_ff == (AW+1)'(mrfr_pkg::QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = buf_ff[rp_ff];

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop  ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         buf_ff[wp_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

### rtl/mrfr_back.sv
`default_nettype none
module mrfr_back #(
   parameter int PEER_SLOTS = mrfr_pkg::PEER_SLOTS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   input  wire mrfr_pkg::cls_type q_data,
   output      logic              q_pop,
   mrfr_rsp_if.source             rsp
);
   localparam int SW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
   localparam int DW = 16 + 16 + 4 + 3;
   localparam int EW = 16 + 8;

   mrfr_pkg::state_type state_ff, state_in;
   logic [SW:0]        scan_ff, scan_in;
   logic [SW-1:0]      slot_ff, slot_in;
   logic               found_ff, found_in, hasfree_ff, hasfree_in;
   logic [SW-1:0]      free_ff, free_in;
   logic [SW-1:0]      chk_ff, chk_in;
   logic               chkv_ff, chkv_in;
   mrfr_pkg::rsp_type  out_ff, out_in;

   logic [PEER_SLOTS-1:0] pval_ff;
   logic [PEER_SLOTS-1:0] popen_ff;

   logic               pv_ff, pa_ff;
   logic [7:0]         ps_ff;
   logic [15:0]        pd_ff;

   logic               pw_en;
   logic [DW-1:0]      pw_data, pr_data;
   logic [15:0]        rd_dest, rd_total;
   logic [3:0]         rd_msg;
   logic [2:0]         rd_nidx;

   logic               pe_wr;
   logic [EW-1:0]      pe_wdata, pe_rdata;
   logic [SW-1:0]      pe_raddr;
   logic [15:0]        pe_addr;
   logic [7:0]         pe_seq;

   mrfr_pkg::req_type  r;
   logic [SW-1:0]      scan_idx;

   // execute results
   mrfr_pkg::rsp_type  ex;
   logic               ex_seq_wr, ex_open_set, ex_open_clr, ex_acked;
   logic [2:0]         nx;

   assign r        = q_data.req;
   assign scan_idx = scan_ff[SW-1:0];
   assign {rd_dest, rd_total, rd_msg, rd_nidx} = pr_data;
   assign {pe_addr, pe_seq} = pe_rdata;

   assign pe_raddr = (state_ff == mrfr_pkg::ST_SCAN) ? scan_idx : slot_ff;
   assign pe_wr    = (state_ff == mrfr_pkg::ST_CLAIM) ||
                     (state_ff == mrfr_pkg::ST_EXEC && ex_seq_wr);
   assign pe_wdata = (state_ff == mrfr_pkg::ST_CLAIM) ? {r.src_addr, 8'd0} :
                     {r.src_addr, r.seq_num};

   mrfr_ram #(.WIDTH(EW), .DEPTH(PEER_SLOTS)) u_peer (
      .clock   (clock),
      .wr_en   (pe_wr),
      .wr_addr (slot_ff),
      .wr_data (pe_wdata),
      .rd_addr (pe_raddr),
      .rd_data (pe_rdata)
   );

   mrfr_ram #(.WIDTH(DW), .DEPTH(PEER_SLOTS)) u_part (
      .clock   (clock),
      .wr_en   (pw_en),
      .wr_addr (slot_ff),
      .wr_data (pw_data),
      .rd_addr (slot_ff),
      .rd_data (pr_data)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mrfr_pkg::ST_IDLE:  if (!q_empty) begin
            state_in = q_data.settled ? mrfr_pkg::ST_OUT : mrfr_pkg::ST_SCAN;
         end
         mrfr_pkg::ST_SCAN:  if (found_ff) begin
            state_in = mrfr_pkg::ST_READ;
         end else if (scan_ff == (SW+1)'(PEER_SLOTS) && !chkv_ff) begin
            state_in = hasfree_ff ? mrfr_pkg::ST_CLAIM : mrfr_pkg::ST_OUT;
         end
         mrfr_pkg::ST_CLAIM: state_in = mrfr_pkg::ST_READ;
         mrfr_pkg::ST_READ:  state_in = mrfr_pkg::ST_WAIT;
         mrfr_pkg::ST_WAIT:  state_in = mrfr_pkg::ST_EXEC;
         mrfr_pkg::ST_EXEC:  state_in = mrfr_pkg::ST_OUT;
         mrfr_pkg::ST_OUT:   if (rsp.ready) begin
            state_in = mrfr_pkg::ST_IDLE;
         end
         default:            state_in = mrfr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ex          = '0;
      ex_seq_wr   = 1'b0;
      ex_open_set = 1'b0;
      ex_open_clr = 1'b0;
      ex_acked    = 1'b0;
      nx          = rd_nidx + 3'd1;
      if (nx == 3'd0) begin
         nx = 3'd1;
      end
      ex.peer_slot = 6'(slot_ff);
      if (q_data.to_me && r.ack_flags[mrfr_pkg::FLAG_REQ]) begin
         ex.send_ack = 1'b1;
         ex.ack_seq  = r.seq_num;
      end
      if (q_data.to_me && r.ack_flags[mrfr_pkg::FLAG_RESP]) begin
         ex.verdict = mrfr_pkg::V_ACK;
         if (pv_ff && r.first_byte == ps_ff && (pd_ff == 16'd0 || r.src_addr == pd_ff)) begin
            if (!pa_ff) begin
               ex_acked       = 1'b1;
               ex.ack_matched = 1'b1;
            end else begin
               ex.ack_duplicate = 1'b1;
            end
         end
      end else if (r.ack_flags[mrfr_pkg::FLAG_RETX] && pe_seq == r.seq_num) begin
         ex.verdict = mrfr_pkg::V_DUP;
      end else begin
         ex_seq_wr = 1'b1;
         if (r.seq_msg == 4'd0) begin
            ex.verdict      = mrfr_pkg::V_SINGLE;
            ex.message_size = r.remaining_size;
            ex.message_dest = r.dest_addr;
         end else if (!popen_ff[slot_ff]) begin
            if (r.seq_idx != 3'd0) begin
               ex.verdict = mrfr_pkg::V_SYNC;
            end else if (r.seq_end) begin
               ex.verdict      = mrfr_pkg::V_COMPLETE;
               ex.message_size = r.remaining_size;
               ex.message_dest = r.dest_addr;
            end else begin
               ex.verdict  = mrfr_pkg::V_FRAG;
               ex_open_set = 1'b1;
            end
         end else if (r.remaining_size >= rd_total || r.seq_msg != rd_msg ||
                      r.dest_addr != rd_dest) begin
            ex.verdict  = mrfr_pkg::V_ERR;
            ex_open_clr = 1'b1;
         end else if (r.seq_idx != nx) begin
            ex.verdict  = mrfr_pkg::V_LOST;
            ex_open_clr = 1'b1;
         end else begin
            ex.write_offset = rd_total - r.remaining_size;
            if (r.seq_end) begin
               ex.verdict      = mrfr_pkg::V_COMPLETE;
               ex.message_size = rd_total;
               ex.message_dest = rd_dest;
               ex_open_clr     = 1'b1;
            end else begin
               ex.verdict = mrfr_pkg::V_FRAG;
            end
         end
      end
   end

   always_comb begin
      scan_in    = scan_ff;
      slot_in    = slot_ff;
      found_in   = found_ff;
      hasfree_in = hasfree_ff;
      free_in    = free_ff;
      chk_in     = chk_ff;
      chkv_in    = 1'b0;
      out_in     = out_ff;
      pw_en      = 1'b0;
      pw_data    = {r.dest_addr, r.remaining_size, r.seq_msg, 3'd0};
      q_pop      = 1'b0;
      unique case (state_ff)
         mrfr_pkg::ST_IDLE: begin
            scan_in    = '0;
            found_in   = 1'b0;
            hasfree_in = 1'b0;
            out_in         = '0;
            out_in.verdict = q_data.early;
         end
         mrfr_pkg::ST_SCAN: begin
            // address issued this cycle, entry checked in the cycle after
            chk_in = scan_idx;
            if (!found_ff && scan_ff != (SW+1)'(PEER_SLOTS)) begin
               chkv_in = 1'b1;
               scan_in = scan_ff + 1'b1;
            end
            if (chkv_ff && !found_ff) begin
               if (pval_ff[chk_ff] && pe_addr == r.src_addr) begin
                  found_in = 1'b1;
                  slot_in  = chk_ff;
               end else if (!hasfree_ff && !pval_ff[chk_ff]) begin
                  hasfree_in = 1'b1;
                  free_in    = chk_ff;
               end
            end
            if (scan_ff == (SW+1)'(PEER_SLOTS) && !chkv_ff && !found_ff) begin
               slot_in = free_ff;
            end
         end
         mrfr_pkg::ST_EXEC: begin
            out_in = ex;
            if (ex_open_set) begin
               pw_en = 1'b1;
            end else if (!ex_open_clr && ex.verdict == mrfr_pkg::V_FRAG) begin
               pw_en   = 1'b1;
               pw_data = {rd_dest, rd_total, rd_msg, nx};
            end
         end
         mrfr_pkg::ST_OUT: begin
            q_pop = rsp.ready;
         end
         default: ;
      endcase
   end

   assign rsp.valid = (state_ff == mrfr_pkg::ST_OUT);
   assign rsp.data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= mrfr_pkg::ST_IDLE;
         pval_ff    <= '0;
         popen_ff   <= '0;
         pv_ff      <= 1'b0;
         pa_ff      <= 1'b0;
         ps_ff      <= '0;
         pd_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == mrfr_pkg::ST_IDLE && !q_empty) begin
            if (r.op == mrfr_pkg::OP_ARM) begin
               pv_ff <= 1'b1;
               ps_ff <= r.seq_num;
               pd_ff <= r.dest_addr;
               pa_ff <= 1'b0;
            end else if (r.op == mrfr_pkg::OP_CLEAR) begin
               pv_ff <= 1'b0;
               pa_ff <= 1'b0;
            end
         end
         if (state_ff == mrfr_pkg::ST_CLAIM) begin
            pval_ff[slot_ff]  <= 1'b1;
            popen_ff[slot_ff] <= 1'b0;
         end
         if (state_ff == mrfr_pkg::ST_EXEC) begin
            if (ex_open_set) begin
               popen_ff[slot_ff] <= 1'b1;
            end
            if (ex_open_clr) begin
               popen_ff[slot_ff] <= 1'b0;
            end
            if (ex_acked) begin
               pa_ff <= 1'b1;
            end
         end
      end
      scan_ff    <= scan_in;
      slot_ff    <= slot_in;
      found_ff   <= found_in;
      hasfree_ff <= hasfree_in;
      free_ff    <= free_in;
      chk_ff     <= chk_in;
      chkv_ff    <= chkv_in;
      out_ff     <= out_in;
   end
endmodule
`default_nettype wire

### rtl/mac_rx_filter_reassembly.sv
`default_nettype none
// Receive MAC header engine. Each item takes one response. Op items and frames
// that fail the header checks (length, address, zero sender) settle in the
// front and go from the idle state straight to the output state, skipping the
// peer table. A frame that reaches the peer table is scanned one slot a cycle
// through a registered read; the longest case is a new peer that is placed in a
// free slot through the claim state. The front queue holds two items while the
// back end works. Configuration writes are taken at any time; change them only
// while no item is in flight.
module mac_rx_filter_reassembly #(
   parameter int PEER_SLOTS   = mrfr_pkg::PEER_SLOTS_DEF,
   parameter int PAYLOAD_MAX  = mrfr_pkg::PAYLOAD_MAX_DEF,
   parameter int HEADER_BYTES = mrfr_pkg::HEADER_BYTES_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   mrfr_req_if.sink   req,
   mrfr_rsp_if.source rsp,
   mrfr_csr_if.sink   csr
);
   logic [15:0]       own_ff, bcast_ff;
   logic              q_push, q_full, q_pop, q_empty;
   mrfr_pkg::cls_type q_in, q_out;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff   <= 16'd0;
         bcast_ff <= 16'hFFFF;
      end else if (csr.valid) begin
         case (csr.index)
            mrfr_pkg::CSR_OWN:   own_ff   <= csr.wdata;
            mrfr_pkg::CSR_BCAST: bcast_ff <= csr.wdata;
            default: ;
         endcase
      end
   end

   mrfr_front #(.PAYLOAD_MAX(PAYLOAD_MAX), .HEADER_BYTES(HEADER_BYTES)) u_front (
      .own_address       (own_ff),
      .broadcast_address (bcast_ff),
      .req               (req),
      .q_push            (q_push),
      .q_data            (q_in),
      .q_full            (q_full)
   );

   mrfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_out)
   );

   mrfr_back #(.PEER_SLOTS(PEER_SLOTS)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_data  (q_out),
      .q_pop   (q_pop),
      .rsp     (rsp)
   );
endmodule
`default_nettype wire

### rtl/mrfr_checker.sv
`default_nettype none
module mrfr_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [3:0] rsp_verdict,
   input wire logic rsp_send_ack,
   input wire logic [7:0] rsp_ack_seq,
   input wire logic rsp_matched,
   input wire logic rsp_dup
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_verdict))
      else $error("response dropped while stalled");
   a_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_verdict <= mrfr_pkg::V_PENDING)
      else $error("bad verdict");
   a_ackseq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_send_ack |-> rsp_ack_seq == 8'd0)
      else $error("ack seq without ack");
   a_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_matched || rsp_dup) |-> rsp_verdict == mrfr_pkg::V_ACK
      && !(rsp_matched && rsp_dup))
      else $error("ack match outside ack verdict");
endmodule

bind mac_rx_filter_reassembly mrfr_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_verdict (rsp.data.verdict),
   .rsp_send_ack(rsp.data.send_ack),
   .rsp_ack_seq (rsp.data.ack_seq),
   .rsp_matched (rsp.data.ack_matched),
   .rsp_dup     (rsp.data.ack_duplicate)
);
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

   localparam int SLOTS    = mrfr_pkg::PEER_SLOTS_DEF;
   localparam int PAY_MAX  = mrfr_pkg::PAYLOAD_MAX_DEF;
   localparam int HDR      = mrfr_pkg::HEADER_BYTES_DEF;
   localparam int N_RANDOM = 400;
   localparam int IDLE_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mrfr_req_if req_ch ();
   mrfr_rsp_if rsp_ch ();
   mrfr_csr_if csr_ch ();

   mac_rx_filter_reassembly uut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch), .csr(csr_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the block
   logic [15:0] my_addr, bcast_addr;
   logic [15:0] peer_addr [SLOTS];
   logic [7:0]  peer_seq [SLOTS];
   logic        frag_open [SLOTS];
   logic [15:0] frag_dest [SLOTS];
   logic [15:0] frag_total [SLOTS];
   logic [3:0]  frag_msg [SLOTS];
   logic [2:0]  frag_idx [SLOTS];
   logic        pend_valid, pend_acked;
   logic [7:0]  pend_seq;
   logic [15:0] pend_dest;

   mrfr_pkg::rsp_type expected_rsp_q [$];
   int errors = 0;
   int items_sent = 0;
   int rsp_seen = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   int ready_pct = 100;
   int verdict_hits [16];

   function automatic int peek_slot(logic [15:0] a);
      if (a == 16'd0) return -1;
      for (int i = 0; i < SLOTS; i++)
         if (peer_addr[i] == a) return i;
      return -1;
   endfunction

   function automatic int claim_slot(logic [15:0] a);
      int s;
      s = peek_slot(a);
      if (s >= 0 || a == 16'd0) return s;
      for (int i = 0; i < SLOTS; i++)
         if (peer_addr[i] == 16'd0) begin
            peer_addr[i] = a;
            peer_seq[i] = 8'd0;
            frag_open[i] = 1'b0;
            return i;
         end
      return -1;
   endfunction

   function automatic mrfr_pkg::rsp_type predict_header(mrfr_pkg::req_type r);
      mrfr_pkg::rsp_type o;
      int s;
      int pay;
      logic to_me, ok;
      logic [2:0] nx;
      o = '0;
      o.verdict = mrfr_pkg::V_PENDING;
      if (r.op == mrfr_pkg::OP_ARM) begin
         pend_valid = 1'b1;
         pend_seq = r.seq_num;
         pend_dest = r.dest_addr;
         pend_acked = 1'b0;
      end else if (r.op == mrfr_pkg::OP_CLEAR) begin
         pend_valid = 1'b0;
         pend_acked = 1'b0;
      end else if (r.op == mrfr_pkg::OP_FRAME) begin
         pay = (r.remaining_size < PAY_MAX) ? int'(r.remaining_size) : PAY_MAX;
         if (int'(r.frame_len) != HDR + pay) o.verdict = mrfr_pkg::V_BADLEN;
         else if (r.dest_addr != bcast_addr && r.dest_addr != my_addr)
            o.verdict = mrfr_pkg::V_NOTADDR;
         else begin
            s = claim_slot(r.src_addr);
            if (s < 0) o.verdict = mrfr_pkg::V_NOPEER;
            else begin
               to_me = (r.dest_addr == my_addr);
               o.peer_slot = s[5:0];
               if (to_me && r.ack_flags[mrfr_pkg::FLAG_REQ]) begin
                  o.send_ack = 1'b1;
                  o.ack_seq = r.seq_num;
               end
               if (to_me && r.ack_flags[mrfr_pkg::FLAG_RESP]) begin
                  o.verdict = mrfr_pkg::V_ACK;
                  if (pend_valid && r.first_byte == pend_seq &&
                      (pend_dest == 16'd0 || r.src_addr == pend_dest)) begin
                     if (!pend_acked) begin
                        pend_acked = 1'b1;
                        o.ack_matched = 1'b1;
                     end else o.ack_duplicate = 1'b1;
                  end
               end else if (r.ack_flags[mrfr_pkg::FLAG_RETX] && peer_seq[s] == r.seq_num) begin
                  o.verdict = mrfr_pkg::V_DUP;
               end else begin
                  peer_seq[s] = r.seq_num;
                  if (r.seq_msg == 4'd0) begin
                     o.verdict = mrfr_pkg::V_SINGLE;
                     o.message_size = r.remaining_size;
                     o.message_dest = r.dest_addr;
                  end else begin
                     ok = 1'b1;
                     if (!frag_open[s]) begin
                        if (r.seq_idx != 3'd0) begin
                           o.verdict = mrfr_pkg::V_SYNC;
                           ok = 1'b0;
                        end else begin
                           frag_open[s] = 1'b1;
                           frag_dest[s] = r.dest_addr;
                           frag_total[s] = r.remaining_size;
                           frag_msg[s] = r.seq_msg;
                           frag_idx[s] = 3'd0;
                        end
                     end else if (r.remaining_size >= frag_total[s] ||
                                  r.seq_msg != frag_msg[s] ||
                                  r.dest_addr != frag_dest[s]) begin
                        o.verdict = mrfr_pkg::V_ERR;
                        frag_open[s] = 1'b0;
                        ok = 1'b0;
                     end else begin
                        nx = frag_idx[s] + 3'd1;
                        if (nx == 3'd0) nx = 3'd1;
                        if (r.seq_idx != nx) begin
                           o.verdict = mrfr_pkg::V_LOST;
                           frag_open[s] = 1'b0;
                           ok = 1'b0;
                        end else begin
                           frag_idx[s] = nx;
                           o.write_offset = frag_total[s] - r.remaining_size;
                        end
                     end
                     if (ok) begin
                        if (r.seq_end) begin
                           o.verdict = mrfr_pkg::V_COMPLETE;
                           o.message_size = frag_total[s];
                           o.message_dest = frag_dest[s];
                           frag_open[s] = 1'b0;
                        end else o.verdict = mrfr_pkg::V_FRAG;
                     end
                  end
               end
            end
         end
      end
      return o;
   endfunction

   function automatic mrfr_pkg::req_type mk(logic [1:0] op, logic [7:0] len,
         logic [15:0] src, logic [15:0] dest, logic [7:0] seq, logic [3:0] msg,
         logic [2:0] idx, logic last, logic [15:0] rem, logic [2:0] flags,
         logic [7:0] fb);
      mrfr_pkg::req_type r;
      r.op = op; r.frame_len = len; r.src_addr = src; r.dest_addr = dest;
      r.seq_num = seq; r.seq_msg = msg; r.seq_idx = idx; r.seq_end = last;
      r.remaining_size = rem; r.ack_flags = flags; r.first_byte = fb;
      return r;
   endfunction

   task automatic send_item(mrfr_pkg::req_type r, bit typed, mrfr_pkg::rsp_type typed_rsp);
      mrfr_pkg::rsp_type p;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 20));
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= r;
      do @(posedge clock); while (!req_ch.ready);
      p = predict_header(r);
      expected_rsp_q.push_back(typed ? typed_rsp : p);
      items_sent++;
      burst_left--;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_csr(mrfr_pkg::csr_type idx, logic [15:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.wdata <= val;
      do @(posedge clock); while (!csr_ch.ready);
      if (idx == mrfr_pkg::CSR_OWN) my_addr = val;
      else bcast_addr = val;
   endtask

   function automatic mrfr_pkg::rsp_type quiet(mrfr_pkg::verdict_type v);
      mrfr_pkg::rsp_type o;
      o = '0;
      o.verdict = v;
      return o;
   endfunction

   task automatic check_field(string name, int e, int a);
      if (e != a) begin
         $error("%s: expected %0d, got %0d", name, e, a);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      mrfr_pkg::rsp_type e;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_seen++;
            if (expected_rsp_q.size() == 0) begin
               $error("unexpected item on response channel");
               errors++;
            end else begin
               e = expected_rsp_q.pop_front();
               verdict_hits[e.verdict]++;
               check_field("verdict", e.verdict, rsp_ch.data.verdict);
               check_field("send_ack", e.send_ack, rsp_ch.data.send_ack);
               check_field("ack_seq", e.ack_seq, rsp_ch.data.ack_seq);
               check_field("ack_matched", e.ack_matched, rsp_ch.data.ack_matched);
               check_field("ack_duplicate", e.ack_duplicate, rsp_ch.data.ack_duplicate);
               check_field("peer_slot", e.peer_slot, rsp_ch.data.peer_slot);
               check_field("write_offset", e.write_offset, rsp_ch.data.write_offset);
               check_field("message_size", e.message_size, rsp_ch.data.message_size);
               check_field("message_dest", e.message_dest, rsp_ch.data.message_dest);
            end
         end
         if ($urandom_range(0, 199) == 0) begin
            case ($urandom_range(0, 2))
               0: ready_pct = 100;
               1: ready_pct = 60;
               default: ready_pct = 20;
            endcase
         end
         rsp_ch.ready <= ($urandom_range(0, 99) < ready_pct);
      end
   end

   task automatic random_item();
      mrfr_pkg::req_type r;
      int k, s;
      logic [15:0] src, dest, rem;
      k = $urandom_range(0, 99);
      r = '0;
      r.first_byte = 8'($urandom_range(0, 255));
      r.seq_num = 8'($urandom_range(0, 255));
      if (k < 5) begin
         r.op = mrfr_pkg::OP_ARM;
         r.dest_addr = ($urandom_range(0, 3) == 0) ? 16'd0 :
                       16'(16'h0100 + $urandom_range(0, 79));
         if ($urandom_range(0, 3) == 0) r.dest_addr = 16'($urandom_range(0, 65535));
      end else if (k < 8) begin
         r.op = mrfr_pkg::OP_CLEAR;
         r.dest_addr = 16'($urandom_range(0, 65535));
      end else if (k < 9) begin
         r.op = mrfr_pkg::OP_NONE;
      end else begin
         r.op = mrfr_pkg::OP_FRAME;
         k = $urandom_range(0, 99);
         if (k < 3) src = 16'd0;
         else if (k < 8) src = 16'($urandom_range(0, 65535));
         else src = 16'(16'h0100 + $urandom_range(0, 79));
         k = $urandom_range(0, 99);
         if (k < 50) dest = my_addr;
         else if (k < 85) dest = bcast_addr;
         else dest = 16'($urandom_range(0, 65535));
         r.src_addr = src;
         r.ack_flags = 3'($urandom_range(0, 7));
         if ($urandom_range(0, 2) == 0) r.ack_flags = 3'd0;
         s = peek_slot(src);
         if (r.ack_flags[mrfr_pkg::FLAG_RESP] && $urandom_range(0, 9) < 6)
            r.first_byte = pend_seq;
         if (s >= 0 && $urandom_range(0, 4) == 0) r.seq_num = peer_seq[s];
         r.seq_end = ($urandom_range(0, 9) < 3);
         if (s >= 0 && frag_open[s] && $urandom_range(0, 9) < 8) begin
            r.seq_msg = frag_msg[s];
            dest = frag_dest[s];
            r.seq_idx = frag_idx[s] + 3'd1;
            if (r.seq_idx == 3'd0) r.seq_idx = 3'd1;
            if (frag_total[s] == 16'd0) rem = 16'd0;
            else rem = 16'($urandom_range(0, frag_total[s] - 1));
            if ($urandom_range(0, 9) == 0) rem = 16'($urandom_range(0, 65535));
            if ($urandom_range(0, 9) == 0) r.seq_idx = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 15) == 0) r.seq_msg = 4'($urandom_range(1, 15));
            if (r.ack_flags[mrfr_pkg::FLAG_RESP] && $urandom_range(0, 1))
               r.ack_flags[mrfr_pkg::FLAG_RESP] = 1'b0;
         end else begin
            r.seq_msg = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
            r.seq_idx = ($urandom_range(0, 9) < 7) ? 3'd0 : 3'($urandom_range(0, 7));
            rem = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 200)) :
                  16'($urandom_range(0, 65535));
            r.seq_end = ($urandom_range(0, 9) < 2);
         end
         r.dest_addr = dest;
         r.remaining_size = rem;
         r.frame_len = 8'(HDR + ((rem < PAY_MAX) ? int'(rem) : PAY_MAX));
         if ($urandom_range(0, 9) == 0) r.frame_len = 8'($urandom_range(0, 255));
      end
      send_item(r, 1'b0, '0);
   endtask

   initial begin
      mrfr_pkg::req_type rows [$];
      bit typed [$];
      mrfr_pkg::rsp_type typed_rsp [$];
      mrfr_pkg::rsp_type pend_rsp;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = mrfr_pkg::CSR_OWN;
      csr_ch.wdata = '0;
      my_addr = 16'd0;
      bcast_addr = 16'hFFFF;
      for (int i = 0; i < SLOTS; i++) begin
         peer_addr[i] = '0; peer_seq[i] = '0; frag_open[i] = 1'b0;
         frag_dest[i] = '0; frag_total[i] = '0; frag_msg[i] = '0; frag_idx[i] = '0;
      end
      pend_valid = 1'b0; pend_acked = 1'b0; pend_seq = '0; pend_dest = '0;
      foreach (verdict_hits[i]) verdict_hits[i] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      pend_rsp = quiet(mrfr_pkg::V_PENDING);
      rows.push_back(mk(mrfr_pkg::OP_NONE, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 4'hF, 3'h7,
                        1'b1, 16'hFFFF, 3'h7, 8'hFF));
      typed.push_back(1); typed_rsp.push_back(pend_rsp);
      rows.push_back(mk(mrfr_pkg::OP_FRAME, 8'd0, 16'd1, 16'd0, 8'd0, 4'd0, 3'd0, 1'b0,
                        16'd5, 3'd0, 8'd0));
      typed.push_back(1); typed_rsp.push_back(quiet(mrfr_pkg::V_BADLEN));
      rows.push_back(mk(mrfr_pkg::OP_FRAME, 8'd13, 16'd1, 16'h5555, 8'd0, 4'd0, 3'd0, 1'b0,
                        16'd5, 3'd0, 8'd0));
      typed.push_back(1); typed_rsp.push_back(quiet(mrfr_pkg::V_NOTADDR));
      rows.push_back(mk(mrfr_pkg::OP_FRAME, 8'd13, 16'd0, 16'd0, 8'd0, 4'd0, 3'd0, 1'b0,
                        16'd5, 3'd0, 8'd0));
      typed.push_back(1); typed_rsp.push_back(quiet(mrfr_pkg::V_NOPEER));
      rows.push_back(mk(mrfr_pkg::OP_FRAME, 8'd8, 16'd1, 16'd0, 8'hFF, 4'd0, 3'd0, 1'b0,
                        16'd0, 3'd1, 8'd0));
      rows.push_back(mk(mrfr_pkg::OP_FRAME, 8'd72, 16'hFFFF, 16'hFFFF, 8'd1, 4'd0, 3'd0,
                        1'b0, 16'hFFFF, 3'd0, 8'd0));
      rows.push_back(mk(mrfr_pkg::OP_ARM, 8'd0, 16'd0, 16'd0, 8'h42, 4'd0, 3'd0, 1'b0,
                        16'd0, 3'd0, 8'd0));
      typed.push_back(0); typed.push_back(0); typed.push_back(1);
      typed_rsp.push_back('0); typed_rsp.push_back('0); typed_rsp.push_back(pend_rsp);
      rows.push_back(mk(mrfr_pkg::OP_FRAME, 8'd8, 16'd1, 16'd0, 8'd2, 4'd0, 3'd0, 1'b0,
                        16'd0, 3'd2, 8'h42));
      rows.push_back(mk(mrfr_pkg::OP_FRAME, 8'd8, 16'd1, 16'd0, 8'd3, 4'd0, 3'd0, 1'b0,
                        16'd0, 3'd2, 8'h42));
      rows.push_back(mk(mrfr_pkg::OP_FRAME, 8'd8, 16'd1, 16'd0, 8'd4, 4'd0, 3'd0, 1'b0,
                        16'd0, 3'd3, 8'h42));
      rows.push_back(mk(mrfr_pkg::OP_FRAME, 8'd10, 16'd1, 16'hFFFF, 8'd5, 4'd0, 3'd0, 1'b0,
                        16'd2, 3'd2, 8'h42));
      rows.push_back(mk(mrfr_pkg::OP_FRAME, 8'd10, 16'd1, 16'hFFFF, 8'd5, 4'd0, 3'd0, 1'b0,
                        16'd2, 3'd4, 8'd0));
      rows.push_back(mk(mrfr_pkg::OP_FRAME, 8'd72, 16'd2, 16'd0, 8'd10, 4'd5, 3'd0, 1'b0,
                        16'd100, 3'd0, 8'd0));
      for (int i = 1; i <= 7; i++)
         rows.push_back(mk(mrfr_pkg::OP_FRAME, 8'd72, 16'd2, 16'd0, 8'(10 + i), 4'd5,
                           3'(i), 1'b0, 16'(100 - 10 * i), 3'd0, 8'd0));
      rows.push_back(mk(mrfr_pkg::OP_FRAME, 8'd18, 16'd2, 16'd0, 8'd20, 4'd5, 3'd1, 1'b1,
                        16'd10, 3'd0, 8'd0));
      rows.push_back(mk(mrfr_pkg::OP_FRAME, 8'd58, 16'd3, 16'd0, 8'd30, 4'd2, 3'd3, 1'b0,
                        16'd50, 3'd0, 8'd0));
      rows.push_back(mk(mrfr_pkg::OP_FRAME, 8'd58, 16'd3, 16'd0, 8'd31, 4'd2, 3'd0, 1'b0,
                        16'd50, 3'd0, 8'd0));
      rows.push_back(mk(mrfr_pkg::OP_FRAME, 8'd68, 16'd3, 16'd0, 8'd32, 4'd2, 3'd1, 1'b0,
                        16'd60, 3'd0, 8'd0));
      rows.push_back(mk(mrfr_pkg::OP_FRAME, 8'd58, 16'd4, 16'd0, 8'd40, 4'd9, 3'd0, 1'b0,
                        16'd50, 3'd0, 8'd0));
      rows.push_back(mk(mrfr_pkg::OP_FRAME, 8'd48, 16'd4, 16'd0, 8'd41, 4'd9, 3'd2, 1'b0,
                        16'd40, 3'd0, 8'd0));
      rows.push_back(mk(mrfr_pkg::OP_CLEAR, 8'd0, 16'd0, 16'd0, 8'd0, 4'd0, 3'd0, 1'b0,
                        16'd0, 3'd0, 8'd0));
      while (typed.size() < rows.size()) begin
         typed.push_back(0);
         typed_rsp.push_back('0);
      end
      typed[rows.size() - 1] = 1;
      typed_rsp[rows.size() - 1] = pend_rsp;
      foreach (rows[i]) send_item(rows[i], typed[i], typed_rsp[i]);
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin
               write_csr(mrfr_pkg::CSR_OWN, 16'h1234);
               write_csr(mrfr_pkg::CSR_BCAST, 16'hFFFF);
            end
            1: begin
               write_csr(mrfr_pkg::CSR_OWN, 16'hFFFF);
               write_csr(mrfr_pkg::CSR_BCAST, 16'h0000);
            end
            2: begin
               write_csr(mrfr_pkg::CSR_OWN, 16'h0000);
               write_csr(mrfr_pkg::CSR_BCAST, 16'h0000);
            end
            3: begin
               write_csr(mrfr_pkg::CSR_OWN, 16'hA5C3);
               write_csr(mrfr_pkg::CSR_BCAST, 16'h5A3C);
            end
            default: begin
               write_csr(mrfr_pkg::CSR_OWN, 16'($urandom_range(0, 65535)));
               write_csr(mrfr_pkg::CSR_BCAST, 16'($urandom_range(0, 65535)));
            end
         endcase
         csr_ch.valid <= 1'b0;
         for (int n = 0; n < N_RANDOM / 5; n++) random_item();
         drain();
      end

      $display("items sent %0d, responses %0d; frag %0d complete %0d ack %0d nopeer %0d",
               items_sent, rsp_seen, verdict_hits[mrfr_pkg::V_FRAG],
               verdict_hits[mrfr_pkg::V_COMPLETE], verdict_hits[mrfr_pkg::V_ACK],
               verdict_hits[mrfr_pkg::V_NOPEER]);
      $display("sync %0d err %0d lost %0d dup %0d single %0d",
               verdict_hits[mrfr_pkg::V_SYNC], verdict_hits[mrfr_pkg::V_ERR],
               verdict_hits[mrfr_pkg::V_LOST], verdict_hits[mrfr_pkg::V_DUP],
               verdict_hits[mrfr_pkg::V_SINGLE]);
      if (errors == 0 && expected_rsp_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

### filelist.f
rtl/mrfr_pkg.sv
rtl/mrfr_if.sv
rtl/mrfr_ram.sv
rtl/mrfr_front.sv
rtl/mrfr_queue.sv
rtl/mrfr_back.sv
rtl/mac_rx_filter_reassembly.sv
rtl/mrfr_checker.sv
tb/tb_top.sv
